// ----- rtl/abtb_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// abtb_pkg
// Shared types, register indexes and blend constants of the tile blitter.
// ============================================================================
package abtb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH = 3'd0,
        CFG_RECT_WIDTH  = 3'd1,
        CFG_RECT_HEIGHT = 3'd2,
        CFG_DEST_X      = 3'd3,
        CFG_DEST_Y      = 3'd4
    } t_cfg_idx;

    localparam logic [10:0] RST_FRAME_WIDTH = 11'd512;
    localparam logic [8:0]  RST_RECT_WIDTH  = 9'd32;
    localparam logic [8:0]  RST_RECT_HEIGHT = 9'd32;

    localparam logic [31:0] MASK_RB    = 32'h00ff00ff;
    localparam logic [31:0] MASK_AG    = 32'hff00ff00;
    localparam logic [31:0] MASK_G     = 32'h0000ff00;
    localparam logic [31:0] ALPHA_ONE  = 32'h01000000;
    localparam logic [7:0]  ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic load;
        logic mul;
        logic fin;
        logic adv;
    } t_addr_ctl;

    typedef struct packed {
        logic hit;
        logic last;
    } t_addr_stat;

    function automatic logic [31:0] swizzle(input logic [31:0] v);
        swizzle = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ----- rtl/abtb_fb_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// abtb_fb_ram
// Framebuffer store: one write port, one read port, registered read data.
// ============================================================================
module abtb_fb_ram #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/abtb_blend.sv -----
`timescale 1ns / 1ps
// ============================================================================
// abtb_blend
// Source-over blend: source terms registered at load, destination merged later.
// ============================================================================
module abtb_blend (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [31:0] i_src,
    input  logic [31:0] i_dst,
    output logic [31:0] o_pix
);
    import abtb_pkg::*;

    logic [31:0] w_s;
    logic [7:0]  w_a;
    logic [7:0]  r_n;
    logic [31:0] r_s_rb;
    logic [31:0] r_s_ag;
    logic [31:0] w_rb;
    logic [31:0] w_ag;

    assign w_s = swizzle(i_src);
    assign w_a = w_s[31:24];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_n    <= ALPHA_FULL - w_a;
            r_s_rb <= {24'd0, w_a} * (w_s & MASK_RB);
            r_s_ag <= {24'd0, w_a} * (ALPHA_ONE | ((w_s & MASK_G) >> 8));
        end
    end

    assign w_rb  = (({24'd0, r_n} * (i_dst & MASK_RB)) + r_s_rb) >> 8;
    assign w_ag  = ({24'd0, r_n} * ((i_dst & MASK_AG) >> 8)) + r_s_ag;
    assign o_pix = (w_rb & MASK_RB) | (w_ag & MASK_AG);

endmodule

// ----- rtl/abtb_addr.sv -----
`timescale 1ns / 1ps
// ============================================================================
// abtb_addr
// Tile registers, column/row counters and the draw address pipeline.
// ============================================================================
module abtb_addr #(
    parameter int FRAME_PIXELS = 262144,
    parameter int MAX_TILE     = 256,
    parameter int AW           = 18
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [abtb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [abtb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  abtb_pkg::t_addr_ctl              i_ctl,
    output abtb_pkg::t_addr_stat             o_stat,
    output logic [AW-1:0]                    o_addr
);
    import abtb_pkg::*;

    localparam int CW    = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
    localparam int BW    = $clog2(MAX_TILE + 1);
    localparam int SW    = ((BW > 9) ? BW : 9) + 1;
    localparam int ROW_W = ((CW > 10) ? CW : 10) + 1;
    localparam int PW    = ROW_W + 11;
    localparam int DW    = PW + 1;
    localparam int FPW   = $clog2(FRAME_PIXELS + 1);
    localparam int CMPW  = (DW > FPW) ? DW : FPW;

    logic [10:0]      r_fw;
    logic [8:0]       r_rw;
    logic [8:0]       r_rh;
    logic [9:0]       r_dx;
    logic [9:0]       r_dy;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [ROW_W-1:0] r_rowsum;
    logic [ROW_W-1:0] r_colsum;
    logic [PW-1:0]    r_prod;
    logic [AW-1:0]    r_addr;
    logic             r_hit;

    logic [SW-1:0]    w_w;
    logic [SW-1:0]    w_h;
    logic             w_row_wrap;
    logic             w_col_wrap;
    logic [DW-1:0]    w_daddr;
    logic [CMPW-1:0]  w_daddr_x;

    assign w_w = (r_rw == 9'd0) ? SW'(1) :
                 ((SW'(r_rw) > SW'(MAX_TILE)) ? SW'(MAX_TILE) : SW'(r_rw));
    assign w_h = (r_rh == 9'd0) ? SW'(1) :
                 ((SW'(r_rh) > SW'(MAX_TILE)) ? SW'(MAX_TILE) : SW'(r_rh));

    assign w_row_wrap = (SW'(r_row) + SW'(1)) >= w_h;
    assign w_col_wrap = (SW'(r_col) + SW'(1)) >= w_w;

    assign w_daddr   = DW'(r_prod) + DW'(r_colsum);
    assign w_daddr_x = CMPW'(w_daddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= RST_FRAME_WIDTH;
            r_rw  <= RST_RECT_WIDTH;
            r_rh  <= RST_RECT_HEIGHT;
            r_dx  <= '0;
            r_dy  <= '0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_WIDTH: r_fw <= i_cfg_data[10:0];
                    CFG_RECT_WIDTH:  r_rw <= i_cfg_data[8:0];
                    CFG_RECT_HEIGHT: r_rh <= i_cfg_data[8:0];
                    CFG_DEST_X:      r_dx <= i_cfg_data[9:0];
                    CFG_DEST_Y:      r_dy <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_ctl.adv) begin
                if (w_row_wrap) begin
                    r_row <= '0;
                    r_col <= w_col_wrap ? '0 : r_col + CW'(1);
                end else begin
                    r_row <= r_row + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rowsum <= ROW_W'(r_dy) + ROW_W'(r_row);
            r_colsum <= ROW_W'(r_dx) + ROW_W'(r_col);
        end
        if (i_ctl.mul) begin
            r_prod <= PW'(r_rowsum) * PW'(r_fw);
        end
        if (i_ctl.fin) begin
            r_addr <= AW'(w_daddr_x);
            r_hit  <= w_daddr_x < CMPW'(FRAME_PIXELS);
        end
    end

    assign o_addr      = r_addr;
    assign o_stat.hit  = r_hit;
    assign o_stat.last = w_row_wrap && w_col_wrap;

endmodule

// ----- rtl/alpha_blend_tile_blitter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alpha_blend_tile_blitter
// ARGB8888 tile blitter with source-over blending into an on-chip framebuffer.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): a transaction is either a draw of
// one BGRA source pixel at the next tile position (column-major order) or a
// read of one framebuffer word. Output channel (o_out_valid / i_out_ready):
// exactly one result transaction per input transaction, in order.
// Each transaction is handled in turn: accept, address multiply, address add
// and bound check, framebuffer read, blend and write-back. A new transaction
// is taken only after the last one has left write-back; the single
// read/modify/write of the framebuffer RAM sets this.
// A finished result sits in the output register, so the next transaction is
// accepted while it waits; a stalled receiver holds the write-back stage and
// then the input channel.
// After reset the framebuffer is cleared one word per cycle with o_in_ready
// low; configuration writes are taken throughout. Registers take effect on
// the next draw; the user must have them written while idle (not enforced).
// ============================================================================
module alpha_blend_tile_blitter #(
    parameter int FRAME_PIXELS = 262144,
    parameter int MAX_TILE     = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [abtb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [abtb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [31:0]                     i_src_pixel,
    input  logic [17:0]                     i_read_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [31:0]                     o_read_pixel,
    output logic                            o_written,
    output logic                            o_blit_done
);
    import abtb_pkg::*;

    localparam int AW   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int FPW  = $clog2(FRAME_PIXELS + 1);
    localparam int RCW  = (FPW > 18) ? FPW : 18;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADR,
        S_RD,
        S_WB
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic          r_req;
    logic [AW-1:0] r_rd_addr;
    logic          r_rd_hit;
    logic          r_out_valid;
    logic [31:0]   r_read_pixel;
    logic          r_written;
    logic          r_done;

    logic          w_accept;
    logic          w_wb_fire;
    t_addr_ctl     w_ctl;
    t_addr_stat    w_stat;
    logic [AW-1:0] w_draw_addr;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [31:0]   w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [31:0]   w_ram_q;
    logic [31:0]   w_blend;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wb_fire  = (r_state == S_WB) && (!r_out_valid || i_out_ready);

    assign w_ctl.load = w_accept && !i_req_type;
    assign w_ctl.mul  = (r_state == S_MUL);
    assign w_ctl.fin  = (r_state == S_ADR);
    assign w_ctl.adv  = w_wb_fire && !r_req;

    abtb_addr #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .MAX_TILE     (MAX_TILE),
        .AW           (AW)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .o_addr      (w_draw_addr)
    );

    abtb_blend u_blend (
        .i_clk  (i_clk),
        .i_load (w_ctl.load),
        .i_src  (i_src_pixel),
        .i_dst  (w_ram_q),
        .o_pix  (w_blend)
    );

    assign w_ram_we    = (r_state == S_CLEAR) || (w_wb_fire && !r_req && w_stat.hit);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr : w_draw_addr;
    assign w_ram_wdata = (r_state == S_CLEAR) ? 32'd0 : w_blend;
    assign w_ram_raddr = r_req ? r_rd_addr : w_draw_addr;

    abtb_fb_ram #(
        .DEPTH (FRAME_PIXELS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_req_type;
            r_rd_addr <= AW'(RCW'(i_read_address));
            r_rd_hit  <= RCW'(i_read_address) < RCW'(FRAME_PIXELS);
        end
        if (w_wb_fire) begin
            r_read_pixel <= (r_req && r_rd_hit) ? w_ram_q : 32'd0;
            r_written    <= !r_req && w_stat.hit;
            r_done       <= !r_req && w_stat.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wb_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(FRAME_PIXELS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:   r_state <= S_ADR;
                S_ADR:   r_state <= S_RD;
                S_RD:    r_state <= S_WB;
                S_WB: begin
                    if (w_wb_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_pixel = r_read_pixel;
    assign o_written    = r_written;
    assign o_blit_done  = r_done;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MUL))
        else $error("accepted transaction did not start the address stage");

    a_write_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && (r_state != S_CLEAR)) |-> ((r_state == S_WB) && !r_req))
        else $error("framebuffer written outside draw write-back");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_fire |=> o_out_valid)
        else $error("write-back did not load a result");

    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_read_pixel != 32'd0)) |-> (!o_written && !o_blit_done))
        else $error("read result carries draw flags");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) || (r_state == S_WB)) |-> !o_in_ready)
        else $error("input ready while busy");

endmodule

// ----- test/alpha_blend_tile_blitter_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// alpha_blend_tile_blitter_tb
// Drives draw and read transactions through the valid/ready channels, with
// random gaps and stalls on both sides. Tile settings change between phases,
// including zero and oversize tile bounds, zero stride and out-of-frame
// placement. A scoreboard keeps its own framebuffer image and tile counters
// and checks every result, field by field, in order.
// ============================================================================
module alpha_blend_tile_blitter_tb;
    import abtb_pkg::*;

    localparam int   FRAME_PIXELS   = 262144;
    localparam int   MAX_TILE       = 256;
    localparam int   RANDOM_ITEMS   = 1400;
    localparam int   WATCHDOG_LIMIT = 800000;
    localparam logic REQ_DRAW       = 1'b0;
    localparam logic REQ_READ       = 1'b1;

    typedef struct packed {
        logic [31:0] pixel;
        logic        written;
        logic        done;
    } t_blit_result;

    class blit_scoreboard;
        bit [31:0]    frame [FRAME_PIXELS];
        bit [10:0]    frame_width;
        bit [8:0]     rect_width;
        bit [8:0]     rect_height;
        bit [9:0]     dest_x;
        bit [9:0]     dest_y;
        int           column;
        int           row;
        int           drawn_addrs[$];
        t_blit_result results_q[$];
        int           errors;

        function new();
            frame_width = RST_FRAME_WIDTH;
            rect_width  = RST_RECT_WIDTH;
            rect_height = RST_RECT_HEIGHT;
            dest_x      = '0;
            dest_y      = '0;
            column      = 0;
            row         = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FRAME_WIDTH: frame_width = data;
                CFG_RECT_WIDTH:  rect_width  = data[8:0];
                CFG_RECT_HEIGHT: rect_height = data[8:0];
                CFG_DEST_X:      dest_x      = data[9:0];
                CFG_DEST_Y:      dest_y      = data[9:0];
                default: ;
            endcase
        endfunction

        function int tile_bound(bit [8:0] size);
            if (size == 0) return 1;
            if (size > MAX_TILE) return MAX_TILE;
            return size;
        endfunction

        function bit [31:0] blend(bit [31:0] d, bit [31:0] s);
            bit [31:0] a;
            bit [31:0] n;
            bit [31:0] rb;
            bit [31:0] ag;
            a  = s >> 24;
            n  = 32'd255 - a;
            rb = (n * (d & MASK_RB) + a * (s & MASK_RB)) >> 8;
            ag = n * ((d & MASK_AG) >> 8) + a * (ALPHA_ONE | ((s & MASK_G) >> 8));
            return (rb & MASK_RB) | (ag & MASK_AG);
        endfunction

        function void note_input(logic req, logic [31:0] src, logic [17:0] raddr);
            t_blit_result res;
            bit [31:0]    argb;
            longint       addr;
            res = '0;
            if (req == REQ_READ) begin
                if (raddr < FRAME_PIXELS) res.pixel = frame[raddr];
            end else begin
                argb = {src[7:0], src[15:8], src[23:16], src[31:24]};
                addr = (longint'(dest_y) + row) * longint'(frame_width)
                       + longint'(dest_x) + column;
                if (addr < FRAME_PIXELS) begin
                    frame[addr] = blend(frame[addr], argb);
                    res.written = 1'b1;
                    drawn_addrs.push_back(int'(addr));
                    if (drawn_addrs.size() > 256) void'(drawn_addrs.pop_front());
                end
                if (row + 1 >= tile_bound(rect_height)) begin
                    row = 0;
                    if (column + 1 >= tile_bound(rect_width)) begin
                        column   = 0;
                        res.done = 1'b1;
                    end else begin
                        column++;
                    end
                end else begin
                    row++;
                end
            end
            results_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] pixel, logic written, logic done);
            t_blit_result want;
            if (results_q.size() == 0) begin
                $error("result transaction with nothing outstanding");
                errors++;
                return;
            end
            want = results_q.pop_front();
            if (pixel !== want.pixel) begin
                $error("read_pixel: expected %h, got %h", want.pixel, pixel);
                errors++;
            end
            if (written !== want.written) begin
                $error("written: expected %b, got %b", want.written, written);
                errors++;
            end
            if (done !== want.done) begin
                $error("blit_done: expected %b, got %b", want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_req_type     = 1'b0;
    logic [31:0]           i_src_pixel    = '0;
    logic [17:0]           i_read_address = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [31:0]           o_read_pixel;
    logic                  o_written;
    logic                  o_blit_done;

    blit_scoreboard sb = new();
    bit             calm = 1'b0;
    int             out_stall = 0;
    int             idle_cycles = 0;

    alpha_blend_tile_blitter #(
        .FRAME_PIXELS(FRAME_PIXELS),
        .MAX_TILE    (MAX_TILE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_src_pixel   (i_src_pixel),
        .i_read_address(i_read_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_pixel  (o_read_pixel),
        .o_written     (o_written),
        .o_blit_done   (o_blit_done)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_pixel();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(0, 5))
            0: p[7:0] = ALPHA_FULL;
            1: p[7:0] = '0;
            default: ;
        endcase
        return p;
    endfunction

    function automatic logic [17:0] pick_read_address();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && sb.drawn_addrs.size() > 0)
            return 18'(sb.drawn_addrs[$urandom_range(0, sb.drawn_addrs.size() - 1)]);
        if (r == 9) return $urandom_range(0, 1) ? '1 : '0;
        return 18'($urandom);
    endfunction

    function automatic int pick_tile_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(MAX_TILE, 511);
        if (r == 2) return $urandom_range(9, 64);
        return $urandom_range(1, 8);
    endfunction

    function automatic int pick_frame_width();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 2047;
        if (r == 2) return $urandom_range(1, 4);
        return $urandom_range(1, 1024);
    endfunction

    function automatic int pick_dest();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1023;
        return $urandom_range(0, 1023);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_read_pixel, o_written, o_blit_done);
        if (out_stall > 0) begin
            i_out_ready <= 1'b0;
            out_stall   <= out_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            out_stall   <= calm ? 0 : pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL alpha_blend_tile_blitter");
            $finish;
        end
    end

    task automatic send_item(logic req, logic [31:0] src, logic [17:0] raddr);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_src_pixel    <= src;
        i_read_address <= raddr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(req, src, raddr);
    endtask

    task automatic set_config(int fw, int rw, int rh, int dx, int dy);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  junk_idx;
        logic [CFG_DATA_W-1:0] junk_data;
        vals = '{CFG_DATA_W'(fw), CFG_DATA_W'(rw), CFG_DATA_W'(rh),
                 CFG_DATA_W'(dx), CFG_DATA_W'(dy)};
        while (sb.results_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= vals[k];
            sb.write_reg(t_cfg_idx'(k), vals[k]);
            @(posedge i_clk);
        end
        if ($urandom_range(0, 3) == 0) begin
            junk_idx  = CFG_IDX_W'($urandom_range(CFG_DEST_Y + 1, (1 << CFG_IDX_W) - 1));
            junk_data = CFG_DATA_W'($urandom);
            i_cfg_index <= junk_idx;
            i_cfg_data  <= junk_data;
            sb.write_reg(junk_idx, junk_data);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase_len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        calm = 1'b1;
        send_item(REQ_DRAW, 32'hFFFF_FFFF, '0);
        send_item(REQ_DRAW, 32'h0000_0000, '0);
        send_item(REQ_DRAW, 32'h1234_5680, '0);
        send_item(REQ_READ, '0, 18'd0);
        send_item(REQ_READ, '0, 18'd1);
        send_item(REQ_READ, '0, 18'd2);
        send_item(REQ_READ, '1, '1);
        i_in_valid <= 1'b0;

        set_config(0, 0, 0, 1023, 1023);
        repeat (3) send_item(REQ_DRAW, pick_pixel(), '0);
        send_item(REQ_READ, '0, 18'd1023);
        i_in_valid <= 1'b0;

        calm = 1'b0;
        set_config(2047, 511, 2, 1023, 1023);
        repeat (3) send_item(REQ_DRAW, pick_pixel(), '0);
        i_in_valid <= 1'b0;

        set_config(1024, 3, 2, 1021, 255);
        repeat (6) send_item(REQ_DRAW, pick_pixel(), '0);
        send_item(REQ_READ, '0, 18'd262141);
        send_item(REQ_READ, '0, 18'd262142);
        i_in_valid <= 1'b0;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            set_config(pick_frame_width(), pick_tile_size(), pick_tile_size(),
                       pick_dest(), pick_dest());
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < 65) begin
                    send_item(REQ_DRAW, pick_pixel(), 18'($urandom));
                end else begin
                    send_item(REQ_READ, $urandom, pick_read_address());
                end
                sent++;
            end
            i_in_valid <= 1'b0;
        end

        while (sb.results_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS alpha_blend_tile_blitter");
        end else begin
            $display("FAIL alpha_blend_tile_blitter");
        end
        $finish;
    end

endmodule
